// ===== hdl/qprpy_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the pose to roll/pitch/yaw block.
`default_nettype none
package qprpy_pkg;

    localparam int QPRPY_CORDIC_STEPS = 16;
    localparam int QPRPY_SQRT_STEPS   = 32;   // one step per root bit of the zero-extended 64-bit radicand
    localparam int QPRPY_TOL_W        = 11;
    localparam int QPRPY_CW           = 34;   // CORDIC x/y width, holds gain growth
    localparam int QPRPY_AW           = 28;   // CORDIC angle width, Q.24 radians

    localparam logic [QPRPY_TOL_W-1:0]    QPRPY_TOL_RESET   = 11'd8;
    localparam logic signed [QPRPY_AW-1:0] QPRPY_HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [QPRPY_AW-1:0] QPRPY_HALF_PI_Q13 = 28'sd12868;
    localparam logic signed [QPRPY_AW-1:0] QPRPY_PI_Q13      = 28'sd25736;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pos;

    // rotation matrix terms, Q.30, saturated to [-1, 1]
    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
    } t_rset;

    // atan(2^-i) in Q.24
    function automatic logic signed [QPRPY_AW-1:0] f_atan_q24(input int i);
        logic signed [QPRPY_AW-1:0] v;
        case (i)
            0: v = 28'sd13176795;
            1: v = 28'sd7778716;
            2: v = 28'sd4110060;
            3: v = 28'sd2086331;
            4: v = 28'sd1047214;
            5: v = 28'sd524117;
            6: v = 28'sd262123;
            7: v = 28'sd131069;
            default: v = (i <= 24) ? QPRPY_AW'(1 << (24 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/qprpy_if.sv =====
// Valid/ready channel interfaces for pose items in and angle items out.
`default_nettype none
interface qprpy_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

interface qprpy_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    modport source (output valid, out_x, out_y, out_z, roll, pitch, yaw, input ready);
    modport sink   (input valid, out_x, out_y, out_z, roll, pitch, yaw, output ready);
endinterface
`default_nettype wire

// ===== hdl/qprpy_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module qprpy_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [61:0] i_sum,
    output logic      [31:0] o_root
);
    import qprpy_pkg::*;

    localparam int SQ = QPRPY_SQRT_STEPS;

    logic [63:0] r_rem  [0:SQ];
    logic [63:0] r_root [0:SQ];
    logic [63:0] n_rem  [0:SQ-1];
    logic [63:0] n_root [0:SQ-1];

    always_comb begin
        for (int k = 0; k < SQ; k++) begin
            logic [63:0] bitv;
            logic [63:0] t;
            bitv = 64'd1 << (62 - 2 * k);
            t    = r_root[k] + bitv;
            if (r_rem[k] >= t) begin
                n_rem[k]  = r_rem[k] - t;
                n_root[k] = (r_root[k] >> 1) + bitv;
            end else begin
                n_rem[k]  = r_rem[k];
                n_root[k] = r_root[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {2'b00, i_sum};
            r_root[0] <= '0;
            for (int k = 0; k < SQ; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[SQ][31:0];

endmodule
`default_nettype wire

// ===== hdl/qprpy_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in Q.24 radians, one micro-rotation per stage.
`default_nettype none
module qprpy_cordic #(
    parameter int STEPS = qprpy_pkg::QPRPY_CORDIC_STEPS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [qprpy_pkg::QPRPY_CW-1:0] i_x,
    input  wire logic signed [qprpy_pkg::QPRPY_CW-1:0] i_y,
    output logic signed [qprpy_pkg::QPRPY_AW-1:0]      o_z
);
    import qprpy_pkg::*;

    logic signed [QPRPY_CW-1:0] r_x [0:STEPS];
    logic signed [QPRPY_CW-1:0] r_y [0:STEPS];
    logic signed [QPRPY_AW-1:0] r_z [0:STEPS];
    logic                       r_zero [0:STEPS];
    logic signed [QPRPY_CW-1:0] n_x [0:STEPS-1];
    logic signed [QPRPY_CW-1:0] n_y [0:STEPS-1];
    logic signed [QPRPY_AW-1:0] n_z [0:STEPS-1];

    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            if (!r_y[k][QPRPY_CW-1]) begin
                n_x[k] = r_x[k] + (r_y[k] >>> k);
                n_y[k] = r_y[k] - (r_x[k] >>> k);
                n_z[k] = r_z[k] + f_atan_q24(k);
            end else begin
                n_x[k] = r_x[k] - (r_y[k] >>> k);
                n_y[k] = r_y[k] + (r_x[k] >>> k);
                n_z[k] = r_z[k] - f_atan_q24(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // left half plane: pre-rotate by a quarter turn
            if (i_x[QPRPY_CW-1] && !i_y[QPRPY_CW-1]) begin
                r_x[0] <= i_y;
                r_y[0] <= -i_x;
                r_z[0] <= QPRPY_HALF_PI_Q24;
            end else if (i_x[QPRPY_CW-1]) begin
                r_x[0] <= -i_y;
                r_y[0] <= i_x;
                r_z[0] <= -QPRPY_HALF_PI_Q24;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            for (int k = 0; k < STEPS; k++) begin
                r_x[k+1]    <= n_x[k];
                r_y[k+1]    <= n_y[k];
                r_z[k+1]    <= n_z[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_z = r_zero[STEPS] ? '0 : r_z[STEPS];

endmodule
`default_nettype wire

// ===== hdl/quaternion_pose_to_roll_pitch_yaw.sv =====
// Top level: base pose (position + unit quaternion) to Z-Y-X roll, pitch and yaw.
//
// Items enter on i_in (valid/ready) and leave on o_out (valid/ready); the
// position is copied through, roll and yaw come out in Q3.13 radians and
// pitch in Q2.13. The pipeline holds quaternion products, matrix terms,
// squares, the sum register, 32 square-root stages, a CORDIC pre-rotation
// plus CORDIC_STEPS micro-rotations, angle scaling, and the gimbal select
// into the output register.
// Throughput is one item per cycle; four CORDIC pipelines (pitch, roll and
// both yaw forms) run side by side and the gimbal test picks at the end.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver stalls, every stage holds and i_in.ready is low.
// gimbal_tolerance is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this. Reset
// (i_rst_n low, synchronous) empties the pipeline and sets the tolerance to 8.
`default_nettype none
module quaternion_pose_to_roll_pitch_yaw #(
    parameter int CORDIC_STEPS = qprpy_pkg::QPRPY_CORDIC_STEPS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [qprpy_pkg::QPRPY_TOL_W-1:0]    i_cfg_wr_data,
    qprpy_in_if.sink                                  i_in,
    qprpy_out_if.source                               o_out
);
    import qprpy_pkg::*;

    localparam int LAT = 39 + CORDIC_STEPS;
    localparam int DR  = 34;   // matrix-term delay, lines up with the root

    logic                    en;
    logic [QPRPY_TOL_W-1:0]  r_tol;
    logic                    r_vld [0:LAT-1];
    t_pos                    r_pos [0:LAT-1];

    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_rset              r_r;
    t_rset              n_r;
    t_rset              r_rd [0:DR-1];
    logic signed [63:0] r_sq21, r_sq22;
    logic [31:0]        w_m;
    logic signed [QPRPY_AW-1:0] w_zp, w_zg, w_zn, w_zr;
    logic signed [14:0] r_p13;
    logic signed [15:0] r_yg13, r_yn13, r_rl13;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;
    logic [14:0]        ap;
    logic               gim;

    function automatic logic signed [31:0] f_sat(input logic signed [34:0] v);
        if (v > 35'sd1073741824)
            return 32'sd1073741824;
        else if (v < -35'sd1073741824)
            return -32'sd1073741824;
        else
            return 32'(v);
    endfunction

    // Q.24 -> Q3.13, round half up, then clamp
    function automatic logic signed [15:0] f_q13(input logic signed [QPRPY_AW-1:0] z,
                                                 input logic signed [QPRPY_AW-1:0] lim);
        logic signed [QPRPY_AW-1:0] t;
        t = (z + QPRPY_AW'(1024)) >>> 11;
        if (t > lim)
            t = lim;
        else if (t < -lim)
            t = -lim;
        return 16'(t);
    endfunction

    assign en         = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= QPRPY_TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++)
                r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LAT; k++)
                r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0] <= '{pos_x: i_in.pos_x, pos_y: i_in.pos_y, pos_z: i_in.pos_z};
            for (int k = 1; k < LAT; k++)
                r_pos[k] <= r_pos[k-1];
        end
    end

    // stage 1: quaternion products, Q2.30
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= i_in.quat_x * i_in.quat_x;
            r_yy <= i_in.quat_y * i_in.quat_y;
            r_zz <= i_in.quat_z * i_in.quat_z;
            r_xy <= i_in.quat_x * i_in.quat_y;
            r_xz <= i_in.quat_x * i_in.quat_z;
            r_yz <= i_in.quat_y * i_in.quat_z;
            r_wx <= i_in.quat_w * i_in.quat_x;
            r_wy <= i_in.quat_w * i_in.quat_y;
            r_wz <= i_in.quat_w * i_in.quat_z;
        end
    end

    // stage 2: matrix terms
    always_comb begin
        n_r.r00 = f_sat(35'sd1073741824 - ((35'(r_yy) + 35'(r_zz)) <<< 1));
        n_r.r01 = f_sat((35'(r_xy) - 35'(r_wz)) <<< 1);
        n_r.r10 = f_sat((35'(r_xy) + 35'(r_wz)) <<< 1);
        n_r.r11 = f_sat(35'sd1073741824 - ((35'(r_xx) + 35'(r_zz)) <<< 1));
        n_r.r20 = f_sat((35'(r_xz) - 35'(r_wy)) <<< 1);
        n_r.r21 = f_sat((35'(r_yz) + 35'(r_wx)) <<< 1);
        n_r.r22 = f_sat(35'sd1073741824 - ((35'(r_xx) + 35'(r_yy)) <<< 1));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r <= n_r;
            // stage 3: squares for the pitch denominator
            r_sq21 <= r_r.r21 * r_r.r21;
            r_sq22 <= r_r.r22 * r_r.r22;
            r_rd[0] <= r_r;
            for (int k = 1; k < DR; k++)
                r_rd[k] <= r_rd[k-1];
        end
    end

    // stage 4 (sum register) and 32 root stages
    qprpy_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sq21[61:0] + r_sq22[61:0]),
        .o_root (w_m)
    );

    qprpy_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (QPRPY_CW'({2'b00, w_m})),
        .i_y   (-QPRPY_CW'(r_rd[DR-1].r20)),
        .o_z   (w_zp)
    );

    qprpy_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw_gim (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (QPRPY_CW'(r_rd[DR-1].r11)),
        .i_y   (QPRPY_CW'(r_rd[DR-1].r01)),
        .o_z   (w_zg)
    );

    qprpy_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (QPRPY_CW'(r_rd[DR-1].r00)),
        .i_y   (QPRPY_CW'(r_rd[DR-1].r10)),
        .o_z   (w_zn)
    );

    qprpy_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (QPRPY_CW'(r_rd[DR-1].r22)),
        .i_y   (QPRPY_CW'(r_rd[DR-1].r21)),
        .o_z   (w_zr)
    );

    assign ap  = r_p13[14] ? 15'(-r_p13) : 15'(r_p13);
    assign gim = (15'(QPRPY_HALF_PI_Q13) - ap) < 15'(r_tol);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p13  <= 15'(f_q13(w_zp, QPRPY_HALF_PI_Q13));
            r_yg13 <= f_q13(w_zg, QPRPY_PI_Q13);
            r_yn13 <= f_q13(w_zn, QPRPY_PI_Q13);
            r_rl13 <= f_q13(w_zr, QPRPY_PI_Q13);
            // near gimbal lock roll folds into yaw
            r_pitch <= r_p13;
            r_roll  <= gim ? 16'sd0 : r_rl13;
            r_yaw   <= gim ? -r_yg13 : r_yn13;
        end
    end

    assign o_out.valid = r_vld[LAT-1];
    assign o_out.out_x = r_pos[LAT-1].pos_x;
    assign o_out.out_y = r_pos[LAT-1].pos_y;
    assign o_out.out_z = r_pos[LAT-1].pos_z;
    assign o_out.roll  = r_roll;
    assign o_out.pitch = r_pitch;
    assign o_out.yaw   = r_yaw;

    a_tol_write: assert property (@(posedge i_clk)
        (i_rst_n && i_cfg_wr_en) |=> (r_tol == $past(i_cfg_wr_data)))
        else $error("tolerance register missed a write");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.pitch <= 15'sd12868 && o_out.pitch >= -15'sd12868))
        else $error("pitch out of range");

    a_roll_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.roll <= 16'sd25736 && o_out.roll >= -16'sd25736 &&
                         o_out.yaw <= 16'sd25736 && o_out.yaw >= -16'sd25736))
        else $error("roll or yaw out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> (!i_in.ready ##1
            (o_out.valid && $stable(o_out.yaw) && $stable(o_out.roll))))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== test/quaternion_pose_to_roll_pitch_yaw_tb.sv =====
// Self-checking testbench for the pose to roll/pitch/yaw converter.
`default_nettype none
module quaternion_pose_to_roll_pitch_yaw_tb;
    import qprpy_pkg::*;

    localparam int LATENCY   = 39 + QPRPY_CORDIC_STEPS;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [QPRPY_TOL_W-1:0] i_cfg_wr_data = '0;

    qprpy_in_if  pose_ch ();
    qprpy_out_if angle_ch ();

    quaternion_pose_to_roll_pitch_yaw u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (pose_ch.sink),
        .o_out        (angle_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_angles pending_angles[$];
    logic [QPRPY_TOL_W-1:0] tol_shadow = QPRPY_TOL_RESET;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    // ---------------- predictor ----------------
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_one(longint v);
        longint one = longint'(1) << 30;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bitv = longint'(1) << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint arc_step(int i);
        case (i)
            0: return 13176795;
            1: return 7778716;
            2: return 4110060;
            3: return 2086331;
            4: return 1047214;
            5: return 524117;
            6: return 262123;
            7: return 131069;
            default: return (i <= 24) ? (longint'(1) << (24 - i)) : 0;
        endcase
    endfunction

    // vectoring atan2, Q.24 radians
    function automatic longint vector_angle(longint y, longint x);
        longint z = 0;
        longint t, dx, dy;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 26353589;
            end else begin
                t = x; x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < QPRPY_CORDIC_STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += arc_step(i);
            end else begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint to_q13(longint z, longint lim);
        return clip(shr_floor(z + 1024, 11), lim);
    endfunction

    function automatic t_angles pose_angles(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] pz, logic signed [15:0] qw,
                                            logic signed [15:0] qx, logic signed [15:0] qy,
                                            logic signed [15:0] qz,
                                            logic [QPRPY_TOL_W-1:0] tol);
        longint w, x, y, z, one;
        longint r00, r01, r10, r11, r20, r21, r22, m, pit, ap, rol, yw;
        t_angles a;
        w = qw; x = qx; y = qy; z = qz;
        one = longint'(1) << 30;
        r00 = sat_one(one - 2 * (y * y + z * z));
        r01 = sat_one(2 * (x * y - w * z));
        r10 = sat_one(2 * (x * y + w * z));
        r11 = sat_one(one - 2 * (x * x + z * z));
        r20 = sat_one(2 * (x * z - w * y));
        r21 = sat_one(2 * (y * z + w * x));
        r22 = sat_one(one - 2 * (x * x + y * y));
        m = int_root(longint'(r21 * r21) + longint'(r22 * r22));
        pit = to_q13(vector_angle(-r20, m), 12868);
        ap = pit < 0 ? -pit : pit;
        if (12868 - ap < longint'(tol)) begin
            rol = 0;
            yw = clip(-to_q13(vector_angle(r01, r11), 25736), 25736);
        end else begin
            yw = to_q13(vector_angle(r10, r00), 25736);
            rol = to_q13(vector_angle(r21, r22), 25736);
        end
        a.x = px; a.y = py; a.z = pz;
        a.roll = rol[15:0]; a.pitch = pit[14:0]; a.yaw = yw[15:0];
        return a;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_angles got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && angle_ch.valid && angle_ch.ready) begin
            got = {angle_ch.out_x, angle_ch.out_y, angle_ch.out_z,
                   angle_ch.roll, angle_ch.pitch, angle_ch.yaw};
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = pending_angles.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // receiver stall, decided at the falling edge
    always @(negedge i_clk)
        angle_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // ---------------- stimulus ----------------
    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic signed [15:0] qw,
                             logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        pose_ch.valid = 1'b1;
        pose_ch.pos_x = px; pose_ch.pos_y = py; pose_ch.pos_z = pz;
        pose_ch.quat_w = qw; pose_ch.quat_x = qx;
        pose_ch.quat_y = qy; pose_ch.quat_z = qz;
        @(posedge i_clk);
        while (!pose_ch.ready) @(posedge i_clk);
        pending_angles.insert(pending_angles.size(),
                              pose_angles(px, py, pz, qw, qx, qy, qz, tol_shadow));
        @(negedge i_clk);
        pose_ch.valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        pose_ch.valid = 1'b0;
        while (pending_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [QPRPY_TOL_W-1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tol_shadow = v;
    endtask

    // random unit-ish quaternion from a random axis/angle-like mix
    task automatic send_random_pose(bit near_lock);
        logic signed [15:0] q[4];
        real a, b, c, d, n;
        if ($urandom_range(9) == 0) begin
            foreach (q[i]) q[i] = 16'($urandom);
        end else begin
            a = $urandom_range(65535) - 32768.0; b = $urandom_range(65535) - 32768.0;
            c = $urandom_range(65535) - 32768.0; d = $urandom_range(65535) - 32768.0;
            if (near_lock) begin
                // pitch near +-90 deg: w ~ +-y, x ~ +-z
                c = (($urandom_range(1)) ? a : -a) + ($urandom_range(40) - 20.0);
                d = (($urandom_range(1)) ? b : -b) + ($urandom_range(40) - 20.0);
            end
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            q[0] = 16'($rtoi(a / n * 32767.0)); q[1] = 16'($rtoi(b / n * 32767.0));
            q[2] = 16'($rtoi(c / n * 32767.0)); q[3] = 16'($rtoi(d / n * 32767.0));
        end
        send_pose($urandom, $urandom, $urandom, q[0], q[1], q[2], q[3]);
    endtask

    task automatic test_directed();
        send_pose(32'sh7fffffff, 32'sh80000000, 0, 16'sh7fff, 0, 0, 0);
        send_pose(32'sh80000000, 32'sh7fffffff, -1, 16'sh8000, 0, 0, 0);
        send_pose(1, 2, 3, 0, 16'sh7fff, 0, 0);
        send_pose(4, 5, 6, 0, 0, 16'sh7fff, 0);
        send_pose(7, 8, 9, 0, 0, 0, 16'sh7fff);
        send_pose(0, 0, 0, 0, 0, 0, 0);                           // all operands zero
        send_pose(-1, -1, -1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_pose(-1, 0, -1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff); // not normalized
        send_pose(0, 0, 0, 23170, 0, 23170, 0);                   // pitch +pi/2
        send_pose(0, 0, 0, 23170, 0, -23170, 0);                  // pitch -pi/2
        send_pose(0, 0, 0, 16384, 16384, 16384, 16384);           // roll and yaw +pi/2, pitch 0
        send_pose(0, 0, 0, 16384, -16384, 16384, -16384);
        send_pose(0, 0, 0, 23170, 23170, 0, 0);
        send_pose(0, 0, 0, 23170, 0, 0, -23170);
        send_pose(0, 0, 0, 0, 16'sh8000, 0, 16'sh7fff);
        send_pose(0, 0, 0, 23100, 0, 23240, 0);                   // just off lock
    endtask

    task automatic test_tolerance_extremes();
        write_tolerance('0);                  // no lock branch
        send_pose(0, 0, 0, 23170, 0, 23170, 0);
        send_pose(0, 0, 0, 16384, 16384, 16384, 16384);
        write_tolerance(11'd1024);
        send_pose(0, 0, 0, 23100, 0, 23240, 0);
        repeat (20) send_random_pose(1'b1);
        write_tolerance(11'h7ff);             // lock branch whenever |pitch| > 10821
        repeat (20) send_random_pose(1'b0);
        write_tolerance(QPRPY_TOL_RESET);
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_random_pose($urandom_range(3) == 0);
    endtask

    task automatic test_pause_until_empty();
        drain();
        repeat (10) send_random_pose(1'b0);
    endtask

    initial begin
        pose_ch.valid = 1'b0;
        pose_ch.pos_x = '0;
        pose_ch.pos_y = '0;
        pose_ch.pos_z = '0;
        pose_ch.quat_w = '0;
        pose_ch.quat_x = '0;
        pose_ch.quat_y = '0;
        pose_ch.quat_z = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_tolerance_extremes();
        test_random_phase(0, 0, 90);
        test_pause_until_empty();
        test_random_phase(59, 0, 80);
        write_tolerance(11'd200);
        test_random_phase(0, 59, 80);
        write_tolerance(11'd37);
        test_random_phase(17, 17, 80);
        test_random_phase(0, 0, 20);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
